[rtl/ild_pkg.sv]
// ild_pkg: shared types, constants and opcode tables for the length decoder
// no dependencies
package ild_pkg;

    localparam int MAX_INSN_LEN = 15;

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_PREFIX = 3'd1;
    localparam logic [2:0] PH_REX    = 3'd2;
    localparam logic [2:0] PH_ESC    = 3'd3;
    localparam logic [2:0] PH_ESC3   = 3'd4;
    localparam logic [2:0] PH_MODRM  = 3'd5;
    localparam logic [2:0] PH_SIB    = 3'd6;
    localparam logic [2:0] PH_TAIL   = 3'd7;

    localparam logic [1:0] ST_MORE  = 2'd0;
    localparam logic [1:0] ST_DONE  = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    localparam logic [1:0] MAP_ONE  = 2'd0;
    localparam logic [1:0] MAP_0F   = 2'd1;
    localparam logic [1:0] MAP_0F38 = 2'd2;
    localparam logic [1:0] MAP_0F3A = 2'd3;

    // flag bits: 0 modrm, 1 i8, 2 i16, 3 iz, 4 iv, 6 io, 7 r8, 8 rz, 9 bad
    localparam logic [9:0] F_N  = 10'h000;
    localparam logic [9:0] F_M  = 10'h001;
    localparam logic [9:0] F_B  = 10'h002;
    localparam logic [9:0] F_W  = 10'h004;
    localparam logic [9:0] F_Z  = 10'h008;
    localparam logic [9:0] F_V  = 10'h010;
    localparam logic [9:0] F_O  = 10'h040;
    localparam logic [9:0] F_J  = 10'h080;
    localparam logic [9:0] F_K  = 10'h100;
    localparam logic [9:0] F_X  = 10'h200;
    localparam logic [9:0] F_MB = 10'h003;
    localparam logic [9:0] F_MZ = 10'h009;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       run_start;
        logic       buffer_last;
    } in_item_t;

    typedef struct packed {
        logic [3:0] insn_length;
        logic [8:0] covered_total;
        logic [1:0] run_status;
    } out_item_t;

    // classified byte handed from front to back
    typedef struct packed {
        logic [7:0] code_byte;
        logic       run_start;
        logic       buffer_last;
        logic [9:0] one_flags;
        logic [9:0] esc_flags;
        logic       legacy;
        logic       rex;
    } class_t;

    function automatic logic [9:0] map_one_f(input logic [7:0] b);
        logic [9:0] f;
        f = F_N;
        unique case (b[7:4])
            4'h0, 4'h1, 4'h2, 4'h3:
            begin
                unique case (b[2:0])
                    3'd4: f = F_B;
                    3'd5: f = F_Z;
                    3'd6, 3'd7: f = F_X;
                    default: f = F_M;
                endcase
                if (b == 8'h0F) f = F_N;
                if (b[7:4] >= 4'h2 && b[2:1] == 2'b11 && !b[0]) f = F_N;
            end
            4'h4, 4'h5, 4'h9:
                f = (b == 8'h9A) ? F_X : F_N;
            4'h6:
            begin
                unique case (b[3:0])
                    4'h0, 4'h1, 4'h2: f = F_X;
                    4'h3: f = F_M;
                    4'h8: f = F_Z;
                    4'h9: f = F_MZ;
                    4'hA: f = F_B;
                    4'hB: f = F_MB;
                    default: f = F_N;
                endcase
            end
            4'h7: f = F_J;
            4'h8:
            begin
                unique case (b[3:0])
                    4'h0, 4'h2, 4'h3: f = F_MB;
                    4'h1: f = F_MZ;
                    default: f = F_M;
                endcase
            end
            4'hA:
            begin
                if (b[3:2] == 2'b00) f = F_O;
                else if (b[3:0] == 4'h8) f = F_B;
                else if (b[3:0] == 4'h9) f = F_Z;
                else f = F_N;
            end
            4'hB: f = b[3] ? F_V : F_B;
            4'hC:
            begin
                unique case (b[3:0])
                    4'h0, 4'h1, 4'h6: f = F_MB;
                    4'h2, 4'h8, 4'hA: f = F_W;
                    4'h4, 4'h5, 4'hE: f = F_X;
                    4'h7: f = F_MZ;
                    4'hD: f = F_B;
                    default: f = F_N;
                endcase
                // enter carries imm16 plus imm8
                if (b == 8'hC8) f = F_W | F_B;
            end
            4'hD:
                f = (b[3:0] == 4'h4 || b[3:0] == 4'h5 || b[3:0] == 4'h6) ? F_X
                  : (b[3:0] == 4'h7) ? F_N : F_M;
            4'hE:
            begin
                unique case (b[3:2])
                    2'b00: f = F_J;
                    2'b01: f = F_B;
                    2'b10: f = (b[1:0] == 2'b10) ? F_X : (b[1] ? F_J : F_K);
                    default: f = F_N;
                endcase
            end
            default:
                f = (b[2:1] == 2'b11) ? F_M : F_N;
        endcase
        return f;
    endfunction

    function automatic logic [9:0] map_0f_f(input logic [7:0] b);
        logic [9:0] f;
        f = F_M;
        unique case (b[7:4])
            4'h0:
            begin
                unique case (b[3:0])
                    4'h0, 4'h1, 4'h2, 4'h3, 4'hD, 4'hF: f = F_M;
                    4'h4, 4'hA, 4'hC: f = F_X;
                    default: f = F_N;
                endcase
            end
            4'h2: f = (b[3:2] == 2'b01) ? F_X : F_M;
            4'h3:
            begin
                unique case (b[3:0])
                    4'h6, 4'h9, 4'hB, 4'hC, 4'hD, 4'hE, 4'hF: f = F_X;
                    default: f = F_N;
                endcase
            end
            4'h7:
            begin
                unique case (b[3:0])
                    4'h0, 4'h1, 4'h2, 4'h3: f = F_MB;
                    4'h7: f = F_N;
                    4'hA, 4'hB: f = F_X;
                    default: f = F_M;
                endcase
            end
            4'h8: f = F_K;
            4'hA:
            begin
                unique case (b[3:0])
                    4'h0, 4'h1, 4'h2, 4'h8, 4'h9, 4'hA: f = F_N;
                    4'h4, 4'hC: f = F_MB;
                    4'h6, 4'h7: f = F_X;
                    default: f = F_M;
                endcase
            end
            4'hB:
                f = (b[3:0] == 4'h9) ? F_X : (b[3:0] == 4'hA) ? F_MB : F_M;
            4'hC:
            begin
                if (b[3]) f = F_N;
                else if (b[2:0] == 3'd2 || b[2:0] == 3'd4 || b[2:0] == 3'd5
                         || b[2:0] == 3'd6) f = F_MB;
                else f = F_M;
            end
            4'hF: f = (b[3:0] == 4'hF) ? F_X : F_M;
            default: f = F_M;
        endcase
        return f;
    endfunction

endpackage

[rtl/x86_64_instruction_length_decoder.sv]
// x86_64_instruction_length_decoder: top level, front classifier, queue, parser
// depends on ild_pkg, ild_front, ild_queue, ild_back
// data path: each byte goes through the front register and the queue to the parser; results are registered
// throughput: one byte per cycle while out_ready does not stall the result register
// reset: asynchronous active low; parser idle, queue empty, cover target 5
module x86_64_instruction_length_decoder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  ild_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output ild_pkg::out_item_t out_data
);
    // cover target register
    logic [7:0] target_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            target_reg <= 8'd5;
        else if (cfg_we)
            target_reg <= cfg_wdata;
    end

    logic            f_valid, f_ready, q_valid, q_ready;
    ild_pkg::class_t f_data, q_data;

    // front: register and table lookup
    ild_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .cls_valid(f_valid), .cls_ready(f_ready), .cls_data(f_data)
    );

    // decoupling queue
    ild_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
    );

    // back: parse state and result register
    ild_back u_back (
        .clk(clk), .rst_n(rst_n), .cover_target(target_reg),
        .cls_valid(q_valid), .cls_ready(q_ready), .cls_data(q_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );
endmodule

[rtl/ild_front.sv]
// ild_front: input register stage, classifies each byte by table lookup
// depends on ild_pkg
module ild_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ild_pkg::in_item_t in_data,
    output logic              cls_valid,
    input  logic              cls_ready,
    output ild_pkg::class_t   cls_data
);
    logic            valid_reg;
    ild_pkg::class_t data_reg;
    logic [7:0]      b;

    assign b         = in_data.code_byte;
    assign in_ready  = !valid_reg || cls_ready;
    assign cls_valid = valid_reg;
    assign cls_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg.code_byte   <= b;
            data_reg.run_start   <= in_data.run_start;
            data_reg.buffer_last <= in_data.buffer_last;
            data_reg.one_flags   <= ild_pkg::map_one_f(b);
            data_reg.esc_flags   <= ild_pkg::map_0f_f(b);
            data_reg.legacy      <= (b == 8'hF0) || (b == 8'hF2) || (b == 8'hF3)
                                 || (b == 8'h2E) || (b == 8'h36) || (b == 8'h3E)
                                 || (b == 8'h26) || (b == 8'h64) || (b == 8'h65)
                                 || (b == 8'h66) || (b == 8'h67);
            data_reg.rex         <= (b[7:4] == 4'h4);
        end
    end
endmodule

[rtl/ild_queue.sv]
// ild_queue: two-entry queue between classifier and parser
// depends on ild_pkg
module ild_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  ild_pkg::class_t wr_data,
    output logic            rd_valid,
    input  logic            rd_ready,
    output ild_pkg::class_t rd_data
);
    ild_pkg::class_t mem_reg [2];
    logic            wp_reg, rp_reg;
    logic [1:0]      cnt_reg;
    logic            wr, rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign wr       = wr_valid && wr_ready;
    assign rd       = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr) wp_reg <= !wp_reg;
            if (rd) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr) mem_reg[wp_reg] <= wr_data;
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'd2) else $error("queue count out of range");
    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2) |-> !wr_ready) else $error("full queue took a write");
    a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
        (wr && !rd) |=> (cnt_reg == $past(cnt_reg) + 2'd1))
        else $error("queue count did not follow write");
`endif
endmodule

[rtl/ild_back.sv]
// ild_back: length parser state machine and result register
// depends on ild_pkg
module ild_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         cover_target,
    input  logic               cls_valid,
    output logic               cls_ready,
    input  ild_pkg::class_t    cls_data,
    output logic               out_valid,
    input  logic               out_ready,
    output ild_pkg::out_item_t out_data
);
    logic [2:0] phase_reg, phase_next;
    logic [3:0] cnt_reg, cnt_next;
    logic [8:0] total_reg, total_next;
    logic       osz_reg, osz_next, asz_reg, asz_next, rexw_reg, rexw_next;
    logic [9:0] flags_reg, flags_next;
    logic [7:0] opv_reg, opv_next;
    logic [1:0] map_reg, map_next;
    logic [7:0] modrm_reg, modrm_next;
    logic [3:0] tail_reg, tail_next;
    logic       ovalid_reg;
    ild_pkg::out_item_t odata_reg;

    logic       take, emit;
    ild_pkg::out_item_t res;
    logic [7:0] b;

    assign cls_ready = !ovalid_reg || out_ready;
    assign take      = cls_valid && cls_ready;
    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;
    assign b         = cls_data.code_byte;

    function automatic logic [3:0] imm_n(input logic [9:0] f, input logic osz,
                                         input logic asz, input logic w);
        logic [3:0] zs;
        logic [3:0] n;
        zs = osz ? 4'd2 : 4'd4;
        n  = 4'd0;
        if (f[1]) n = n + 4'd1;
        if (f[2]) n = n + 4'd2;
        if (f[3]) n = n + zs;
        if (f[4]) n = n + (w ? 4'd8 : zs);
        if (f[6]) n = n + (asz ? 4'd4 : 4'd8);
        if (f[7]) n = n + 4'd1;
        if (f[8]) n = n + zs;
        return n;
    endfunction

    always_comb
    begin
        logic [2:0] ph;
        logic [3:0] c;
        logic [8:0] tot;
        logic       fin, bad;
        logic [9:0] e;
        logic       use_e;
        logic [3:0] disp;
        logic       sib;
        logic [9:0] fl;
        phase_next = phase_reg; cnt_next = cnt_reg; total_next = total_reg;
        osz_next = osz_reg; asz_next = asz_reg; rexw_next = rexw_reg;
        flags_next = flags_reg; opv_next = opv_reg; map_next = map_reg;
        modrm_next = modrm_reg; tail_next = tail_reg;
        emit = 1'b0;
        res  = '0;
        fin = 1'b0; bad = 1'b0; e = '0; use_e = 1'b0; disp = '0; sib = 1'b0;
        fl = '0; tot = total_reg;
        ph = phase_reg; c = cnt_reg;
        if (cls_data.run_start)
        begin
            tot = '0; c = '0; ph = ild_pkg::PH_PREFIX;
            osz_next = 1'b0; asz_next = 1'b0; rexw_next = 1'b0; flags_next = '0;
            opv_next = '0; map_next = '0; modrm_next = '0; tail_next = '0;
        end
        phase_next = ph; total_next = tot; cnt_next = c;
        if (ph != ild_pkg::PH_IDLE)
        begin
            if (c >= 4'(ild_pkg::MAX_INSN_LEN))
                bad = 1'b1;
            else
            begin
                cnt_next = c + 4'd1;
                unique case (ph)
                    ild_pkg::PH_PREFIX, ild_pkg::PH_REX:
                    begin
                        if (ph == ild_pkg::PH_PREFIX && cls_data.legacy)
                        begin
                            if (b == 8'h66) osz_next = 1'b1;
                            if (b == 8'h67) asz_next = 1'b1;
                        end
                        else if (cls_data.rex)
                        begin
                            rexw_next  = b[3];
                            phase_next = ild_pkg::PH_REX;
                        end
                        else if (b == 8'h62 || b == 8'hC4 || b == 8'hC5)
                            bad = 1'b1;
                        else
                        begin
                            opv_next = b;
                            if (b == 8'h0F)
                            begin
                                map_next   = ild_pkg::MAP_0F;
                                phase_next = ild_pkg::PH_ESC;
                            end
                            else
                            begin
                                map_next = ild_pkg::MAP_ONE;
                                e = cls_data.one_flags; use_e = 1'b1;
                            end
                        end
                    end
                    ild_pkg::PH_ESC:
                    begin
                        opv_next = b;
                        if (b == 8'h38)
                        begin
                            map_next = ild_pkg::MAP_0F38; phase_next = ild_pkg::PH_ESC3;
                        end
                        else if (b == 8'h3A)
                        begin
                            map_next = ild_pkg::MAP_0F3A; phase_next = ild_pkg::PH_ESC3;
                        end
                        else
                        begin
                            e = cls_data.esc_flags; use_e = 1'b1;
                        end
                    end
                    ild_pkg::PH_ESC3:
                    begin
                        opv_next = b;
                        e = (map_reg == ild_pkg::MAP_0F3A) ? ild_pkg::F_MB : ild_pkg::F_M;
                        use_e = 1'b1;
                    end
                    ild_pkg::PH_MODRM:
                    begin
                        modrm_next = b;
                        if (asz_reg)
                        begin
                            if (b[7:6] == 2'd0 && b[2:0] == 3'd6) disp = 4'd2;
                            else if (b[7:6] == 2'd1) disp = 4'd1;
                            else if (b[7:6] == 2'd2) disp = 4'd2;
                        end
                        else if (b[7:6] != 2'd3)
                        begin
                            sib = (b[2:0] == 3'd4);
                            if (b[7:6] == 2'd0) disp = (b[2:0] == 3'd5) ? 4'd4 : 4'd0;
                            else disp = (b[7:6] == 2'd1) ? 4'd1 : 4'd4;
                        end
                        fl = flags_reg;
                        if (map_reg == ild_pkg::MAP_ONE && b[5:4] == 2'b00)
                        begin
                            if (opv_reg == 8'hF6) fl = fl | ild_pkg::F_B;
                            else if (opv_reg == 8'hF7) fl = fl | ild_pkg::F_Z;
                        end
                        flags_next = fl;
                        tail_next  = disp + imm_n(fl, osz_reg, asz_reg, rexw_reg);
                        if (sib) phase_next = ild_pkg::PH_SIB;
                        else if (tail_next == 4'd0) fin = 1'b1;
                        else phase_next = ild_pkg::PH_TAIL;
                    end
                    ild_pkg::PH_SIB:
                    begin
                        // sib base of 5 with mod 0 adds disp32
                        if (modrm_reg[7:6] == 2'd0 && b[2:0] == 3'd5)
                            tail_next = tail_reg + 4'd4;
                        if (tail_next == 4'd0) fin = 1'b1;
                        else phase_next = ild_pkg::PH_TAIL;
                    end
                    default:
                    begin
                        if (tail_reg != 4'd0) tail_next = tail_reg - 4'd1;
                        if (tail_next == 4'd0) fin = 1'b1;
                    end
                endcase
                if (use_e)
                begin
                    if (e[9]) bad = 1'b1;
                    else
                    begin
                        flags_next = e;
                        if (e[0]) phase_next = ild_pkg::PH_MODRM;
                        else
                        begin
                            tail_next = imm_n(e, osz_next, asz_next, rexw_next);
                            if (tail_next == 4'd0) fin = 1'b1;
                            else phase_next = ild_pkg::PH_TAIL;
                        end
                    end
                end
            end
            if (bad)
            begin
                emit = 1'b1;
                res  = '{4'd0, tot, ild_pkg::ST_ERROR};
                phase_next = ild_pkg::PH_IDLE;
            end
            else if (fin)
            begin
                total_next = tot + {5'd0, cnt_next};
                emit = 1'b1;
                if (total_next >= {1'b0, cover_target})
                begin
                    res = '{cnt_next, total_next, ild_pkg::ST_DONE};
                    phase_next = ild_pkg::PH_IDLE;
                end
                else if (cls_data.buffer_last)
                begin
                    res = '{4'd0, total_next, ild_pkg::ST_ERROR};
                    phase_next = ild_pkg::PH_IDLE;
                end
                else
                begin
                    res = '{cnt_next, total_next, ild_pkg::ST_MORE};
                    phase_next = ild_pkg::PH_PREFIX;
                    cnt_next = '0; osz_next = 1'b0; asz_next = 1'b0;
                    rexw_next = 1'b0; flags_next = '0; opv_next = '0;
                    map_next = '0; modrm_next = '0; tail_next = '0;
                end
            end
            else if (cls_data.buffer_last)
            begin
                emit = 1'b1;
                res  = '{4'd0, tot, ild_pkg::ST_ERROR};
                phase_next = ild_pkg::PH_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ild_pkg::PH_IDLE; cnt_reg <= '0; total_reg <= '0;
            osz_reg <= 1'b0; asz_reg <= 1'b0; rexw_reg <= 1'b0;
            flags_reg <= '0; opv_reg <= '0; map_reg <= '0;
            modrm_reg <= '0; tail_reg <= '0; ovalid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                phase_reg <= phase_next; cnt_reg <= cnt_next; total_reg <= total_next;
                osz_reg <= osz_next; asz_reg <= asz_next; rexw_reg <= rexw_next;
                flags_reg <= flags_next; opv_reg <= opv_next; map_reg <= map_next;
                modrm_reg <= modrm_next; tail_reg <= tail_next;
            end
            if (cls_ready) ovalid_reg <= take && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit) odata_reg <= res;
    end

`ifndef SYNTH
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("result changed while stalled");
    a_err_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.run_status == ild_pkg::ST_ERROR) |->
        (out_data.insn_length == 4'd0)) else $error("error with nonzero length");
    a_idle_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == ild_pkg::PH_PREFIX) |-> (cnt_reg <= 4'd15))
        else $error("byte count out of range");
`endif
endmodule
